>>> rtl/msfix_pkg.sv
// Shared types, constants and the parity table for the Mode S parity fixer.
package msfix_pkg;

  localparam int LongBits   = 112;
  localparam int StoreDepth = 14;
  localparam logic [6:0] NoPos = 7'd127;

  // Result status codes
  localparam logic [2:0] StatGood    = 3'd0;
  localparam logic [2:0] StatOneFix  = 3'd1;
  localparam logic [2:0] StatTwoFix  = 3'd2;
  localparam logic [2:0] StatUncorr  = 3'd3;
  localparam logic [2:0] StatBadLen  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } msfix_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [2:0]  status;
    logic [6:0]  first_error_pos;
    logic [6:0]  second_error_pos;
    logic [23:0] computed_parity;
  } msfix_out_t;

  // Per-cell control, one request per cycle at most
  typedef struct packed {
    logic write;
    logic rotate;
    logic advance;
  } cell_ctl_t;

  localparam logic [23:0] PARITY_TABLE [LongBits] = '{
    24'h3935ea, 24'h1c9af5, 24'hf1b77e, 24'h78dbbf, 24'hc397db, 24'h9e31e9, 24'hb0e2f0,
    24'h587178, 24'h2c38bc, 24'h161c5e, 24'h0b0e2f, 24'hfa7d13, 24'h82c48d, 24'hbe9842,
    24'h5f4c21, 24'hd05c14, 24'h682e0a, 24'h341705, 24'he5f186, 24'h72f8c3, 24'hc68665,
    24'h9cb936, 24'h4e5c9b, 24'hd8d449, 24'h939020, 24'h49c810, 24'h24e408, 24'h127204,
    24'h093902, 24'h049c81, 24'hfdb444, 24'h7eda22, 24'h3f6d11, 24'he04c8c, 24'h702646,
    24'h381323, 24'he3f395, 24'h8e03ce, 24'h4701e7, 24'hdc7af7, 24'h91c77f, 24'hb719bb,
    24'ha476d9, 24'hadc168, 24'h56e0b4, 24'h2b705a, 24'h15b82d, 24'hf52612, 24'h7a9309,
    24'hc2b380, 24'h6159c0, 24'h30ace0, 24'h185670, 24'h0c2b38, 24'h06159c, 24'h030ace,
    24'h018567, 24'hff38b7, 24'h80665f, 24'hbfc92b, 24'ha01e91, 24'haff54c, 24'h57faa6,
    24'h2bfd53, 24'hea04ad, 24'h8af852, 24'h457c29, 24'hdd4410, 24'h6ea208, 24'h375104,
    24'h1ba882, 24'h0dd441, 24'hf91024, 24'h7c8812, 24'h3e4409, 24'he0d800, 24'h706c00,
    24'h383600, 24'h1c1b00, 24'h0e0d80, 24'h0706c0, 24'h038360, 24'h01c1b0, 24'h00e0d8,
    24'h00706c, 24'h003836, 24'h001c1b, 24'hfff409,
    24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
    24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
    24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0
  };

  // Syndrome change caused by flipping message bit k
  function automatic logic [23:0] flip_effect(logic [6:0] k, logic is_long);
    logic [7:0] nb;
    logic [6:0] idx;
    logic [7:0] sh;
    nb  = is_long ? 8'd112 : 8'd56;
    idx = is_long ? k : k + 7'd56;
    sh  = nb - 8'd1 - {1'b0, k};
    if (({1'b0, k} + 8'd24) < nb) begin
      return PARITY_TABLE[idx];
    end
    return 24'd1 << sh[4:0];
  endfunction

endpackage

>>> rtl/mode_s_crc_bit_error_fix.sv
// Top level: Mode S parity check with single and two-bit correction.
//
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid / in_stall | in_data   (msfix_in_t)
//  out      | output    | out_valid/out_stall | out_data  (msfix_out_t)
//  cfg      | input     | cfg_we              | cfg_data  (fix_level)
//
// A non-final byte is stored in the chain. A final byte of a valid length starts
// the check: the byte chain rotates past the parity table bit by bit over the
// message, then a check step, then, as fix_level allows, a single-bit search and
// a pair search (one pair per cycle), then one result per cycle while out_stall
// is low. Input is stalled from the final byte until the last result is taken.
// Reset sets fix_level to 1.
module mode_s_crc_bit_error_fix
  import msfix_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  msfix_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output msfix_out_t out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PARITY, S_CHECK, S_SINGLE, S_PAIR_J, S_PAIR_I, S_EMIT, S_BAD
  } state_t;

  state_t      state;
  logic [1:0]  fix_level;
  logic [3:0]  count;
  logic        ovf;
  logic        is_long;
  logic [6:0]  k;
  logic [6:0]  j;
  logic [3:0]  e;
  logic [23:0] parity;
  logic [23:0] syndrome;
  logic [23:0] fej;
  logic [2:0]  status;
  logic [6:0]  pos1;
  logic [6:0]  pos2;

  logic [7:0]  q [StoreDepth];
  cell_ctl_t   ctl [StoreDepth];

  logic        in_acc;
  logic        out_acc;
  logic [3:0]  count_next;
  logic        ovf_next;
  logic [6:0]  last_bit;
  logic [3:0]  last_byte_idx;
  logic [23:0] recv;
  logic [23:0] synd_now;
  logic [23:0] fe_k;
  logic [7:0]  m1;
  logic [7:0]  m2;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == S_EMIT) || (state == S_BAD);
  assign out_acc   = out_valid && !out_stall;

  assign count_next    = (count < 4'(StoreDepth)) ? count + 4'd1 : count;
  assign ovf_next      = ovf || (count == 4'(StoreDepth));
  assign last_bit      = is_long ? 7'd111 : 7'd55;
  assign last_byte_idx = is_long ? 4'd13 : 4'd6;
  assign recv          = is_long ? {q[11], q[12], q[13]} : {q[4], q[5], q[6]};
  assign synd_now      = parity ^ recv;
  assign fe_k          = flip_effect(k, is_long);

  // Byte chain of cells
  for (genvar c = 0; c < StoreDepth; c++) begin : g_cell
    logic       nb;
    logic [7:0] nbyte;
    if (c == StoreDepth - 1) begin : g_end
      assign nb    = q[0][7];
      assign nbyte = q[c];
    end else if (c == 6) begin : g_mid
      assign nb    = is_long ? q[c+1][7] : q[0][7];
      assign nbyte = q[c+1];
    end else begin : g_body
      assign nb    = q[c+1][7];
      assign nbyte = q[c+1];
    end
    assign ctl[c].write   = in_acc && (count == 4'(c));
    assign ctl[c].rotate  = (state == S_PARITY);
    assign ctl[c].advance = (state == S_EMIT) && out_acc;
    msfix_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[c]),
      .load_byte (in_data.data_byte),
      .next_bit  (nb),
      .next_byte (nbyte),
      .q         (q[c])
    );
  end

  // Correction masks for the byte at the head of the chain
  assign m1 = (pos1[6:3] == e) ? (8'h80 >> pos1[2:0]) : 8'h00;
  assign m2 = (pos2[6:3] == e) ? (8'h80 >> pos2[2:0]) : 8'h00;

  always_comb begin
    if (state == S_BAD) begin
      out_data.out_byte         = 8'd0;
      out_data.out_last         = 1'b1;
      out_data.status           = StatBadLen;
      out_data.first_error_pos  = NoPos;
      out_data.second_error_pos = NoPos;
      out_data.computed_parity  = 24'd0;
    end else begin
      out_data.out_byte         = q[0] ^ m1 ^ m2;
      out_data.out_last         = (e == last_byte_idx);
      out_data.status           = status;
      out_data.first_error_pos  = pos1;
      out_data.second_error_pos = pos2;
      out_data.computed_parity  = parity;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_level <= 2'd1;
    end else if (cfg_we) begin
      fix_level <= cfg_data;
    end
  end

  // Sequencer: collect, parity scan, searches, emit, or a bad-length result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= 4'd0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            count <= count_next;
            ovf   <= ovf_next;
            if (in_data.last_byte) begin
              if (ovf_next || (count_next != 4'd7 && count_next != 4'd14)) begin
                state <= S_BAD;
              end else begin
                state   <= S_PARITY;
                is_long <= (count_next == 4'd14);
                k       <= 7'd0;
                parity  <= 24'd0;
              end
            end
          end
        end
        S_PARITY: begin
          if (q[0][7] && (({1'b0, k} + 8'd24) < ({1'b0, last_bit} + 8'd1))) begin
            parity <= parity ^ fe_k;
          end
          if (k == last_bit) begin
            state <= S_CHECK;
          end else begin
            k <= k + 7'd1;
          end
        end
        S_CHECK: begin
          syndrome <= synd_now;
          pos1     <= NoPos;
          pos2     <= NoPos;
          e        <= 4'd0;
          k        <= 7'd0;
          j        <= 7'd0;
          if (synd_now == 24'd0) begin
            status <= StatGood;
            state  <= S_EMIT;
          end else if (fix_level != 2'd0) begin
            status <= StatUncorr;
            state  <= S_SINGLE;
          end else begin
            status <= StatUncorr;
            state  <= S_EMIT;
          end
        end
        S_SINGLE: begin
          if (fe_k == syndrome) begin
            status <= StatOneFix;
            pos1   <= k;
            state  <= S_EMIT;
          end else if (k == last_bit) begin
            state <= fix_level[1] ? S_PAIR_J : S_EMIT;
          end else begin
            k <= k + 7'd1;
          end
        end
        S_PAIR_J: begin
          fej   <= flip_effect(j, is_long);
          k     <= j + 7'd1;
          state <= S_PAIR_I;
        end
        S_PAIR_I: begin
          if ((fej ^ fe_k) == syndrome) begin
            status <= StatTwoFix;
            pos1   <= j;
            pos2   <= k;
            state  <= S_EMIT;
          end else if (k == last_bit) begin
            if (j == last_bit - 7'd1) begin
              state <= S_EMIT;
            end else begin
              j     <= j + 7'd1;
              state <= S_PAIR_J;
            end
          end else begin
            k <= k + 7'd1;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (e == last_byte_idx) begin
              state <= S_IDLE;
              count <= 4'd0;
              ovf   <= 1'b0;
            end else begin
              e <= e + 4'd1;
            end
          end
        end
        S_BAD: begin
          if (out_acc) begin
            state <= S_IDLE;
            count <= 4'd0;
            ovf   <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/msfix_cell.sv
// One byte cell of the message chain: load, bit rotate, or byte advance.
module msfix_cell
  import msfix_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] load_byte,
  input  logic       next_bit,
  input  logic [7:0] next_byte,
  output logic [7:0] q
);

  // Hold unless told to load, rotate a bit in from the neighbor, or take its byte
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      q <= load_byte;
    end else if (ctl.rotate) begin
      q <= {q[6:0], next_bit};
    end else if (ctl.advance) begin
      q <= next_byte;
    end
  end

endmodule

>>> bench/tb.sv
// Testbench for the Mode S parity checker with single and two-bit correction.
module tb;
  import msfix_pkg::*;

  localparam int CycleLimit = 3000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  msfix_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  msfix_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd1;

  mode_s_crc_bit_error_fix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [23:0] bit_syn [LongBits];
  logic [7:0]  held_bytes [StoreDepth];
  int          held_cnt = 0;
  bit          held_ovf = 1'b0;
  logic [1:0]  fix_now = 2'd1;

  msfix_in_t  byte_reqs [$];
  msfix_out_t fixed_bytes [$];
  int         queued_cnt = 0;
  int         taken_cnt = 0;
  int         mismatches = 0;
  int         cycles = 0;
  bit         no_idle = 1'b0;
  int         send_gap = 0;
  int         hold_left = 0;

  // Table of parity contributions, derived from the generator polynomial
  function automatic void build_syn_table();
    logic [24:0] acc;
    for (int k = 0; k < LongBits; k++) bit_syn[k] = '0;
    acc = 25'h0fff409;
    bit_syn[87] = acc[23:0];
    for (int k = 87; k > 0; k--) begin
      acc = {acc[23:0], 1'b0};
      if (acc[24]) acc = acc ^ 25'h1fff409;
      bit_syn[k-1] = acc[23:0];
    end
  endfunction

  function automatic logic [23:0] bit_effect(int k, int nbits);
    int ofs;
    ofs = (nbits == LongBits) ? 0 : 56;
    if (k + 24 < nbits) return bit_syn[k + ofs];
    return 24'd1 << (nbits - 1 - k);
  endfunction

  function automatic logic [23:0] calc_parity(logic [7:0] b [StoreDepth], int nbits);
    logic [23:0] p;
    p = '0;
    for (int k = 0; k + 24 < nbits; k++)
      if (b[k/8][7 - k%8]) p ^= bit_effect(k, nbits);
    return p;
  endfunction

  // Take one accepted byte and queue the results it causes
  function automatic void take_byte(msfix_in_t rq);
    msfix_out_t r;
    int nbits, p1, p2;
    logic [23:0] par, syn;
    logic [2:0] st;
    bit found;
    if (held_cnt < StoreDepth) begin
      held_bytes[held_cnt] = rq.data_byte;
      held_cnt++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!rq.last_byte) return;
    if (held_ovf || (held_cnt != 7 && held_cnt != 14)) begin
      r = '{out_byte: 8'd0, out_last: 1'b1, status: StatBadLen, first_error_pos: NoPos,
            second_error_pos: NoPos, computed_parity: 24'd0};
      fixed_bytes.push_back(r);
      held_cnt = 0;
      held_ovf = 1'b0;
      return;
    end
    nbits = held_cnt * 8;
    par = calc_parity(held_bytes, nbits);
    syn = par ^ {held_bytes[held_cnt-3], held_bytes[held_cnt-2], held_bytes[held_cnt-1]};
    p1 = NoPos;
    p2 = NoPos;
    found = 1'b0;
    st = StatGood;
    if (syn != 0) begin
      st = StatUncorr;
      if (fix_now >= 1)
        for (int k = 0; k < nbits && !found; k++)
          if (bit_effect(k, nbits) == syn) begin
            found = 1'b1; p1 = k; st = StatOneFix;
          end
      if (fix_now >= 2 && !found)
        for (int j = 0; j < nbits && !found; j++)
          for (int i = j + 1; i < nbits && !found; i++)
            if ((bit_effect(j, nbits) ^ bit_effect(i, nbits)) == syn) begin
              found = 1'b1; p1 = j; p2 = i; st = StatTwoFix;
            end
    end
    if (p1 != NoPos) held_bytes[p1/8][7 - p1%8] ^= 1'b1;
    if (p2 != NoPos) held_bytes[p2/8][7 - p2%8] ^= 1'b1;
    for (int k = 0; k < held_cnt; k++) begin
      r.out_byte = held_bytes[k];
      r.out_last = (k + 1 == held_cnt);
      r.status = st;
      r.first_error_pos = p1[6:0];
      r.second_error_pos = p2[6:0];
      r.computed_parity = par;
      fixed_bytes.push_back(r);
    end
    held_cnt = 0;
    held_ovf = 1'b0;
  endfunction

  // Driver: present queued byte requests, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(in_data);
        taken_cnt++;
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (byte_reqs.size() > 0) begin
        in_data <= byte_reqs.pop_front();
        in_valid <= 1'b1;
        send_gap <= no_idle ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls, compare each accepted result with the oldest one due
  always @(posedge clk) begin
    int nxt;
    msfix_out_t want;
    nxt = hold_left;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (fixed_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = fixed_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last ||
              out_data.status !== want.status ||
              out_data.first_error_pos !== want.first_error_pos ||
              out_data.second_error_pos !== want.second_error_pos ||
              out_data.computed_parity !== want.computed_parity) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p actual %p", want, out_data);
          end
        end
        nxt = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!out_stall || nxt == 0 || hold_left > 0) begin
        if (nxt > 0 && !(out_valid && !out_stall)) nxt = nxt - 1;
      end
    end
    hold_left <= nxt;
    out_stall <= (nxt > 0);
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Build one message; nerr < 0 or a bad length leaves the parity bytes as filled
  task automatic send_msg(int n, int nerr, int fill);
    logic [7:0] b [StoreDepth];
    logic [7:0] extra;
    logic [23:0] p;
    int k1, k2;
    msfix_in_t rq;
    for (int k = 0; k < StoreDepth; k++)
      b[k] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
    if (nerr >= 0 && (n == 7 || n == 14)) begin
      p = calc_parity(b, n * 8);
      {b[n-3], b[n-2], b[n-1]} = p;
      k1 = $urandom_range(0, n * 8 - 1);
      k2 = (k1 + $urandom_range(1, n * 8 - 1)) % (n * 8);
      if (nerr >= 1) b[k1/8][7 - k1%8] ^= 1'b1;
      if (nerr >= 2) b[k2/8][7 - k2%8] ^= 1'b1;
      if (nerr >= 3) begin
        k1 = $urandom_range(0, n * 8 - 1);
        b[k1/8][7 - k1%8] ^= 1'b1;
      end
    end
    for (int k = 0; k < n; k++) begin
      extra = 8'($urandom_range(0, 255));
      rq.data_byte = (k < StoreDepth) ? b[k] : extra;
      rq.last_byte = (k == n - 1);
      byte_reqs.push_back(rq);
      queued_cnt++;
    end
  endtask

  task automatic random_msgs(int nbytes);
    int goal;
    goal = queued_cnt + nbytes;
    while (queued_cnt < goal) begin
      if ($urandom_range(0, 9) == 0) send_msg($urandom_range(1, 20), -1, -1);
      else send_msg($urandom_range(0, 1) ? 14 : 7, $urandom_range(0, 3), -1);
    end
  endtask

  // Pause the sender until every result is back, then let the block settle
  task automatic drain();
    wait (taken_cnt == queued_cnt && fixed_bytes.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_fix(logic [1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    fix_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    build_syn_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: clean and single-error messages, bad lengths, overlong
    send_msg(7, 0, 0);
    send_msg(7, 1, 255);
    send_msg(1, -1, -1);
    send_msg(15, -1, 255);
    send_msg(8, -1, 0);
    random_msgs(15);
    drain();

    // No correction, back-to-back with no idling
    set_fix(2'd0);
    no_idle = 1'b1;
    send_msg(14, 1, -1);
    random_msgs(15);
    drain();
    no_idle = 1'b0;

    set_fix(2'd2);
    send_msg(7, 2, 0);
    send_msg(14, 2, 255);
    random_msgs(20);

    set_fix(2'd3);
    random_msgs(15);

    set_fix(2'd1);
    random_msgs(10);
    drain();

    repeat (50) @(posedge clk);
    if (fixed_bytes.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
